// ===== design/brle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants of the byte run-length encoder: byte width, packet
// limits and the run header base.
// ----------------------------------------------------------------------------
package brle_pkg;

    // width of one stream byte
    localparam int BYTE_W = 8;

    // default cap on the bytes of one literal packet
    localparam int MAX_LITERAL_DEF = 31;

    // longest run that one run packet carries
    localparam int MAX_RUN = 128;

    // a run of n bytes is headed by RUN_HDR_BASE + n
    localparam logic [BYTE_W-1:0] RUN_HDR_BASE = 8'd127;

endpackage

// ===== design/brle_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_in_if
// Pixel channel: one image byte per transfer, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface brle_in_if;

    logic                        valid;
    logic                        ready;
    logic [brle_pkg::BYTE_W-1:0] pixel;
    logic                        end_of_image;

    modport source (output valid, output pixel, output end_of_image, input ready);
    modport sink   (input valid, input pixel, input end_of_image, output ready);

endinterface

// ===== design/brle_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_out_if
// Code channel: one byte of the compressed stream per transfer, with a flag
// on the final byte produced for an input transfer.
// ----------------------------------------------------------------------------
interface brle_out_if;

    logic                        valid;
    logic                        ready;
    logic [brle_pkg::BYTE_W-1:0] code_byte;
    logic                        last;

    modport source (output valid, output code_byte, output last, input ready);
    modport sink   (input valid, input code_byte, input last, output ready);

endinterface

// ===== design/brle_lit_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_lit_mem
// Literal store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module brle_lit_mem #(
    parameter int DEPTH = brle_pkg::MAX_LITERAL_DEF,
    parameter int AW    = 5
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [brle_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [brle_pkg::BYTE_W-1:0] rd_data
);

    logic [brle_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [brle_pkg::BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/brle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brle_ctrl
// Packet sequencer: tracks the pending run, appends literal bytes to the
// store, and walks run and literal packets out through the output register.
// ----------------------------------------------------------------------------
module brle_ctrl #(
    parameter int MAX_LITERAL = brle_pkg::MAX_LITERAL_DEF,
    parameter int LIT_AW      = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    brle_in_if.sink                     pixels,
    brle_out_if.source                  stream,
    output logic                        wr_en,
    output logic [LIT_AW-1:0]           wr_addr,
    output logic [brle_pkg::BYTE_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [LIT_AW-1:0]           rd_addr,
    input  logic [brle_pkg::BYTE_W-1:0] rd_data
);

    localparam int LIT_CW = $clog2(MAX_LITERAL + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN_HDR,
        S_RUN_VAL,
        S_FL_HDR,
        S_FL_DATA,
        S_FIN
    } state_t;

    // where to go once the current packet is out
    typedef enum logic [1:0] {
        R_IDLE,
        R_FIN,
        R_FLUSH
    } ret_t;

    state_t                      state_reg,    state_next;
    ret_t                        ret_reg,      ret_next;
    logic [brle_pkg::BYTE_W-1:0] held_reg,     held_next;
    logic [7:0]                  rl_reg,       rl_next;
    logic [LIT_CW-1:0]           lcount_reg,   lcount_next;
    logic [LIT_CW-1:0]           idx_reg,      idx_next;
    logic [brle_pkg::BYTE_W-1:0] em_hdr_reg,   em_hdr_next;
    logic [brle_pkg::BYTE_W-1:0] em_val_reg,   em_val_next;
    logic                        out_valid_reg, out_valid_next;
    logic [brle_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;

    logic                        out_free;
    logic [LIT_CW-1:0]           lc_inc;
    logic [brle_pkg::BYTE_W-1:0] run_hdr;
    logic                        at_max_run;
    logic                        store_full;

    assign out_free   = !out_valid_reg || stream.ready;
    assign lc_inc     = lcount_reg + LIT_CW'(1);
    assign run_hdr    = brle_pkg::RUN_HDR_BASE + rl_reg;
    assign at_max_run = (rl_reg >= 8'(brle_pkg::MAX_RUN));
    assign store_full = (lc_inc >= LIT_CW'(MAX_LITERAL));

    assign pixels.ready     = (state_reg == S_IDLE);
    assign stream.valid     = out_valid_reg;
    assign stream.code_byte = out_byte_reg;
    assign stream.last      = out_last_reg;

    // next-state and store access
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        held_next      = held_reg;
        rl_next        = rl_reg;
        lcount_next    = lcount_reg;
        idx_next       = idx_reg;
        em_hdr_next    = em_hdr_reg;
        em_val_next    = em_val_reg;
        out_valid_next = out_valid_reg && !stream.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = lcount_reg[LIT_AW-1:0];
        wr_data        = held_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[LIT_AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (pixels.valid)
                begin
                    ret_next   = pixels.end_of_image ? R_FIN : R_IDLE;
                    state_next = pixels.end_of_image ? S_FIN : S_IDLE;
                    priority if (rl_reg == 8'd0)
                    begin
                        held_next = pixels.pixel;
                        rl_next   = 8'd1;
                    end
                    else if (pixels.pixel == held_reg)
                    begin
                        if (at_max_run)
                        begin
                            // full run goes out, new run of one starts
                            em_hdr_next = run_hdr;
                            em_val_next = held_reg;
                            rl_next     = 8'd1;
                            state_next  = S_RUN_HDR;
                        end
                        else
                        begin
                            rl_next = rl_reg + 8'd1;
                            // a run of two closes any open literal packet
                            if (rl_reg == 8'd1 && lcount_reg != '0)
                            begin
                                state_next = S_FL_HDR;
                            end
                        end
                    end
                    else
                    begin
                        if (rl_reg >= 8'd2)
                        begin
                            em_hdr_next = run_hdr;
                            em_val_next = held_reg;
                            state_next  = S_RUN_HDR;
                        end
                        else
                        begin
                            // lone byte joins the literal packet
                            wr_en       = 1'b1;
                            lcount_next = lc_inc;
                            if (store_full)
                            begin
                                state_next = S_FL_HDR;
                            end
                        end
                        held_next = pixels.pixel;
                        rl_next   = 8'd1;
                    end
                end
            end

            S_FIN:
            begin
                // end of image: flush pending run or byte, then literals
                held_next = '0;
                rl_next   = 8'd0;
                ret_next  = R_IDLE;
                priority if (rl_reg >= 8'd2)
                begin
                    em_hdr_next = run_hdr;
                    em_val_next = held_reg;
                    ret_next    = (lcount_reg != '0) ? R_FLUSH : R_IDLE;
                    state_next  = S_RUN_HDR;
                end
                else if (rl_reg == 8'd1)
                begin
                    wr_en       = 1'b1;
                    lcount_next = lc_inc;
                    state_next  = S_FL_HDR;
                end
                else
                begin
                    state_next = (lcount_reg != '0) ? S_FL_HDR : S_IDLE;
                end
            end

            S_RUN_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = em_hdr_reg;
                    out_last_next  = 1'b0;
                    state_next     = S_RUN_VAL;
                end
            end

            S_RUN_VAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = em_val_reg;
                    out_last_next  = (ret_reg == R_IDLE);
                    unique case (ret_reg)
                        R_FIN:
                        begin
                            state_next = S_FIN;
                        end
                        R_FLUSH:
                        begin
                            ret_next   = R_IDLE;
                            state_next = S_FL_HDR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FL_HDR:
            begin
                // header n-1, first store read issued alongside
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = brle_pkg::BYTE_W'(lcount_reg) - 8'd1;
                    out_last_next  = 1'b0;
                    rd_en          = 1'b1;
                    rd_addr        = '0;
                    idx_next       = LIT_CW'(1);
                    state_next     = S_FL_DATA;
                end
            end

            S_FL_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data;
                    out_last_next  = 1'b0;
                    if (idx_reg == lcount_reg)
                    begin
                        out_last_next = (ret_reg == R_IDLE);
                        lcount_next   = '0;
                        unique case (ret_reg)
                            R_FIN:
                            begin
                                state_next = S_FIN;
                            end
                            R_FLUSH:
                            begin
                                ret_next   = R_IDLE;
                                state_next = S_FL_HDR;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + LIT_CW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= R_IDLE;
            held_reg      <= '0;
            rl_reg        <= 8'd0;
            lcount_reg    <= '0;
            idx_reg       <= '0;
            em_hdr_reg    <= '0;
            em_val_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            held_reg      <= held_next;
            rl_reg        <= rl_next;
            lcount_reg    <= lcount_next;
            idx_reg       <= idx_next;
            em_hdr_reg    <= em_hdr_next;
            em_val_reg    <= em_val_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

// ===== design/byte_run_length_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_length_encoder_top
// PackBits-style byte run-length encoder: pixel bytes in, code bytes out.
// ----------------------------------------------------------------------------
// Each pixel transfer yields zero or more code bytes, the final one flagged
// with last. Runs of 2 to 128 equal bytes are sent as 127+n and the value;
// other bytes are gathered into literal packets (header n-1, then n bytes)
// of at most MAX_LITERAL bytes, kept in a small single-port-write literal
// store. A pixel that produces code bytes holds the input until all are in
// the output register, which sends one byte per cycle while the sink is
// ready; a literal flush reads the store one entry per cycle in step, and
// end_of_image adds a pass through the final flush state. The output
// register lets the next pixel be taken while the last code byte still
// waits on a stalled sink. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module byte_run_length_encoder_top #(
    parameter int MAX_LITERAL = brle_pkg::MAX_LITERAL_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    brle_in_if.sink    pixels,
    brle_out_if.source stream
);

    localparam int LIT_AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    logic                        wr_en;
    logic [LIT_AW-1:0]           wr_addr;
    logic [brle_pkg::BYTE_W-1:0] wr_data;
    logic                        rd_en;
    logic [LIT_AW-1:0]           rd_addr;
    logic [brle_pkg::BYTE_W-1:0] rd_data;

    // packet sequencer
    brle_ctrl #(
        .MAX_LITERAL (MAX_LITERAL),
        .LIT_AW      (LIT_AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .stream  (stream),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // literal store
    brle_lit_mem #(
        .DEPTH (MAX_LITERAL),
        .AW    (LIT_AW)
    ) u_lit_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
